/* hw/rtl/oidl_pkg.sv */
// Package for the ordered id list engine.
// Holds opcode, status and select codes plus the control/status bundles
// passed between controller and datapath. No dependencies.
`default_nettype none

package oidl_pkg;

    localparam int ID_W   = 16;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LIST   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SEL_ECHO  = 2'd0,
        SEL_RDATA = 2'd1,
        SEL_ZERO  = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     latch;
        logic     rd_step;
        logic     rm_proc;
        logic     append_wr;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     out_load;
        t_status  out_status;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  idx_end;
        logic  dv;
        logic  found;
        logic  slot_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hw/rtl/oidl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read data holds until the next read. No dependencies.
`default_nettype none

module oidl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/oidl_dp.sv */
// Datapath: input latch, id store RAM, count and index registers, output register.
// Depends on oidl_pkg and oidl_ram.
`default_nettype none

module oidl_dp #(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [oidl_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [oidl_pkg::ID_W-1:0]    i_entry_id,
    input  wire oidl_pkg::t_dp_cmd            i_cmd,
    output oidl_pkg::t_dp_sts                 o_sts,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [oidl_pkg::STAT_W-1:0]       o_status,
    output logic [oidl_pkg::ID_W-1:0]         o_out_id,
    output logic                              o_is_last,
    output logic [CW-1:0]                     o_entry_count
);

    oidl_pkg::t_mode             r_mode;
    logic [oidl_pkg::ID_W-1:0]   r_id;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_idx, n_idx;
    logic                        r_dv;
    logic                        r_found, n_found;
    logic                        r_out_valid, n_out_valid;
    logic [oidl_pkg::STAT_W-1:0] r_out_status;
    logic [oidl_pkg::ID_W-1:0]   r_out_id, n_out_id;
    logic                        r_out_last;
    logic [CW-1:0]               r_out_count;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [oidl_pkg::ID_W-1:0]   ram_wdata;
    logic [oidl_pkg::ID_W-1:0]   ram_rdata;
    logic                        match;

    oidl_ram #(
        .WIDTH (oidl_pkg::ID_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_step),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign match = (ram_rdata == r_id);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = r_id;
        if (i_cmd.append_wr) begin
            ram_we = 1'b1;
        end else if (i_cmd.rm_proc && r_found) begin
            // shift down by one behind the removed entry
            ram_we    = 1'b1;
            ram_waddr = AW'(r_idx - CW'(2));
            ram_wdata = ram_rdata;
        end
    end

    always_comb begin
        n_found = r_found;
        if (i_cmd.latch) begin
            n_found = 1'b0;
        end else if (i_cmd.rm_proc && !r_found && match) begin
            n_found = 1'b1;
        end

        n_idx = r_idx;
        if (i_cmd.latch) begin
            n_idx = '0;
        end else if (i_cmd.rd_step) begin
            n_idx = r_idx + CW'(1);
        end

        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end

        case (i_cmd.out_sel)
            oidl_pkg::SEL_ECHO:  n_out_id = r_id;
            oidl_pkg::SEL_RDATA: n_out_id = ram_rdata;
            default:             n_out_id = '0;
        endcase

        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_dv        <= i_cmd.rd_step;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= oidl_pkg::t_mode'(i_mode);
            r_id   <= i_entry_id;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_id     <= n_out_id;
            r_out_last   <= i_cmd.out_last;
            r_out_count  <= n_count;
        end
    end

    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.full      = (r_count == CW'(DEPTH));
        o_sts.empty     = (r_count == '0);
        o_sts.idx_end   = (r_idx == r_count);
        o_sts.dv        = r_dv;
        o_sts.found     = r_found;
        o_sts.slot_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_id      = r_out_id;
    assign o_is_last     = r_out_last;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire

/* hw/rtl/oidl_ctrl.sv */
// Controller FSM: sequences append, remove (scan and shift) and list walks.
// Depends on oidl_pkg.
`default_nettype none

module oidl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire oidl_pkg::t_dp_sts i_sts,
    output oidl_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_RM_RUN  = 6'b000100,
        S_RM_DONE = 6'b001000,
        S_LS_EMIT = 6'b010000,
        S_SPARE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state            = r_state;
        o_in_ready         = 1'b0;
        o_cmd              = '0;
        o_cmd.out_status   = oidl_pkg::ST_OK;
        o_cmd.out_sel      = oidl_pkg::SEL_ECHO;
        o_cmd.out_last     = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.mode)
                    oidl_pkg::MODE_APPEND: begin
                        if (i_sts.slot_free) begin
                            o_cmd.out_load = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.out_status = oidl_pkg::ST_FULL;
                            end else begin
                                o_cmd.append_wr = 1'b1;
                                o_cmd.cnt_inc   = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    oidl_pkg::MODE_REMOVE: begin
                        if (!i_sts.empty) begin
                            n_state = S_RM_RUN;
                        end else if (i_sts.slot_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = oidl_pkg::ST_EMPTY;
                            n_state          = S_IDLE;
                        end
                    end
                    oidl_pkg::MODE_LIST: begin
                        if (!i_sts.empty) begin
                            o_cmd.rd_step = 1'b1;
                            n_state       = S_LS_EMIT;
                        end else if (i_sts.slot_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = oidl_pkg::ST_EMPTY;
                            o_cmd.out_sel    = oidl_pkg::SEL_ZERO;
                            n_state          = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_sts.slot_free) begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                endcase
            end
            S_RM_RUN: begin
                o_cmd.rd_step = !i_sts.idx_end;
                o_cmd.rm_proc = i_sts.dv;
                if (i_sts.dv && i_sts.idx_end) begin
                    n_state = S_RM_DONE;
                end
            end
            S_RM_DONE: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = i_sts.found ? oidl_pkg::ST_OK : oidl_pkg::ST_NOT_FOUND;
                    o_cmd.cnt_dec    = i_sts.found;
                    n_state          = S_IDLE;
                end
            end
            S_LS_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = oidl_pkg::SEL_RDATA;
                    o_cmd.out_last = i_sts.idx_end;
                    if (i_sts.idx_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ordered_id_list_engine_top.sv */
// Top level of the ordered id list engine: controller plus datapath.
// Depends on oidl_pkg, oidl_ctrl, oidl_dp (and oidl_ram through it).
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_mode, i_entry_id
//  out     | o_out_valid | i_out_ready | o_status, o_out_id, o_is_last, o_entry_count
//
// Append and unused mode: latched in the idle state, answered from the exec state. Remove: a scan
// of the stored entries, one RAM read per entry while the scan shifts later entries down.
// List: one beat per cycle from the single RAM read port while the output does not stall.
// One item in work at a time; o_in_ready is high only when the controller is idle.
// Output stalls hold the beat in the output register and pause the walk.
// Synchronous active-low reset empties the list; the RAM is not cleared.
`default_nettype none

module ordered_id_list_engine_top #(
    parameter int DEPTH = 16,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [oidl_pkg::MODE_W-1:0] i_mode,
    input  wire logic [oidl_pkg::ID_W-1:0]   i_entry_id,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [oidl_pkg::STAT_W-1:0]      o_status,
    output logic [oidl_pkg::ID_W-1:0]        o_out_id,
    output logic                             o_is_last,
    output logic [CW-1:0]                    o_entry_count
);

    oidl_pkg::t_dp_cmd dp_cmd;
    oidl_pkg::t_dp_sts dp_sts;

    oidl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    oidl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_mode),
        .i_entry_id    (i_entry_id),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_out_id      (o_out_id),
        .o_is_last     (o_is_last),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

/* hw/rtl/oidl_chk.sv */
// Port-level checker for the ordered id list engine, bound to the top level.
// Depends on oidl_pkg.
`default_nettype none

module oidl_chk #(
    parameter int DEPTH = 16,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [oidl_pkg::STAT_W-1:0] o_status,
    input wire logic [oidl_pkg::ID_W-1:0]   o_out_id,
    input wire logic                        o_is_last,
    input wire logic [CW-1:0]               o_entry_count
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_id) && $stable(o_status) && $stable(o_is_last))
        else $error("stalled beat changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_mid_list_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |-> o_status == oidl_pkg::ST_OK)
        else $error("non-final beat with error status");

    a_empty_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_status != oidl_pkg::ST_EMPTY || o_entry_count == '0) &&
            (o_status != oidl_pkg::ST_FULL || o_entry_count == CW'(DEPTH)))
        else $error("status disagrees with entry count");

endmodule

bind ordered_id_list_engine_top oidl_chk #(
    .DEPTH (DEPTH)
) u_oidl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_out_id      (o_out_id),
    .o_is_last     (o_is_last),
    .o_entry_count (o_entry_count)
);

`default_nettype wire

/* bench/ordered_id_list_engine_top_test.sv */
// Testbench for ordered_id_list_engine_top: a directed table, then biased random ops.
// Each output beat is checked against the table's typed beat or a queue-based list predictor.
// Depends on oidl_pkg and the engine RTL.

module ordered_id_list_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int HALF_PERIOD  = 5;
    localparam int RANDOM_ITEMS = 155;
    localparam int PHASE_LEN    = 40;
    localparam int IDLE_PCT     = 37;
    localparam int HOLD_AT_BEAT = 40;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 4 * DEPTH;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIRECTED_N   = 25;

    typedef struct packed {
        oidl_pkg::t_status         status;
        logic [oidl_pkg::ID_W-1:0] id;
        logic                      last;
        logic [CW-1:0]             count;
    } t_beat;

    typedef struct packed {
        logic [oidl_pkg::MODE_W-1:0] mode;
        logic [oidl_pkg::ID_W-1:0]   id;
        logic                        typed;
        t_beat                       res;
    } t_op_row;

    localparam t_beat FROM_MODEL = '0;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic [oidl_pkg::MODE_W-1:0]   i_mode      = '0;
    logic [oidl_pkg::ID_W-1:0]     i_entry_id  = '0;
    logic                          i_out_ready = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [oidl_pkg::STAT_W-1:0]   o_status;
    logic [oidl_pkg::ID_W-1:0]     o_out_id;
    logic                          o_is_last;
    logic [CW-1:0]                 o_entry_count;

    logic [oidl_pkg::ID_W-1:0] model_ids[$];
    t_beat           op_beats[$];
    t_beat           expected_beats[$];
    int unsigned     fail_count  = 0;
    int unsigned     cycle_count = 0;
    int unsigned     beats_seen  = 0;
    int unsigned     hold_left   = 0;
    bit              hold_done   = 1'b0;
    t_beat           exp_beat;

    t_op_row directed_rows [DIRECTED_N] = '{
        '{oidl_pkg::MODE_LIST,   16'h0000, 1'b1, '{oidl_pkg::ST_EMPTY, 16'h0000, 1'b1, 5'd0}},
        '{oidl_pkg::MODE_REMOVE, 16'hFFFF, 1'b1, '{oidl_pkg::ST_EMPTY, 16'hFFFF, 1'b1, 5'd0}},
        '{oidl_pkg::MODE_NOP,    16'hA5A5, 1'b1, '{oidl_pkg::ST_OK,    16'hA5A5, 1'b1, 5'd0}},
        '{oidl_pkg::MODE_APPEND, 16'h0000, 1'b1, '{oidl_pkg::ST_OK,    16'h0000, 1'b1, 5'd1}},
        '{oidl_pkg::MODE_APPEND, 16'hFFFF, 1'b1, '{oidl_pkg::ST_OK,    16'hFFFF, 1'b1, 5'd2}},
        '{oidl_pkg::MODE_REMOVE, 16'h1234, 1'b1,
          '{oidl_pkg::ST_NOT_FOUND, 16'h1234, 1'b1, 5'd2}},
        '{oidl_pkg::MODE_APPEND, 16'h5A5A, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'hFFFF, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h8000, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h0001, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h1234, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'hABCD, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h00FF, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'hFF00, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h0F0F, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'hF0F0, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h3333, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'hCCCC, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h7FFF, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h8001, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_APPEND, 16'h4321, 1'b1, '{oidl_pkg::ST_FULL, 16'h4321, 1'b1, 5'd16}},
        '{oidl_pkg::MODE_LIST,   16'h0000, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_REMOVE, 16'hFFFF, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_REMOVE, 16'h8001, 1'b0, FROM_MODEL},
        '{oidl_pkg::MODE_REMOVE, 16'h0000, 1'b0, FROM_MODEL}
    };

    ordered_id_list_engine_top #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_entry_id    (i_entry_id),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_id      (o_out_id),
        .o_is_last     (o_is_last),
        .o_entry_count (o_entry_count)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_beat make_beat(input oidl_pkg::t_status status,
                                        input logic [oidl_pkg::ID_W-1:0] id,
                                        input logic last);
        t_beat b;
        b.status = status;
        b.id     = id;
        b.last   = last;
        b.count  = CW'(model_ids.size());
        return b;
    endfunction

    // Apply one op to the list model; the beats it causes land in op_beats.
    function automatic void predict_list_op(input logic [oidl_pkg::MODE_W-1:0] mode,
                                            input logic [oidl_pkg::ID_W-1:0] id);
        int pos;
        pos = -1;
        op_beats.delete();
        case (mode)
            oidl_pkg::MODE_APPEND: begin
                if (model_ids.size() >= DEPTH) begin
                    op_beats.push_back(make_beat(oidl_pkg::ST_FULL, id, 1'b1));
                end else begin
                    model_ids.push_back(id);
                    op_beats.push_back(make_beat(oidl_pkg::ST_OK, id, 1'b1));
                end
            end
            oidl_pkg::MODE_REMOVE: begin
                if (model_ids.size() == 0) begin
                    op_beats.push_back(make_beat(oidl_pkg::ST_EMPTY, id, 1'b1));
                end else begin
                    for (int i = 0; i < model_ids.size(); i++) begin
                        if (pos < 0 && model_ids[i] == id) pos = i;
                    end
                    if (pos < 0) begin
                        op_beats.push_back(make_beat(oidl_pkg::ST_NOT_FOUND, id, 1'b1));
                    end else begin
                        model_ids.delete(pos);
                        op_beats.push_back(make_beat(oidl_pkg::ST_OK, id, 1'b1));
                    end
                end
            end
            oidl_pkg::MODE_LIST: begin
                if (model_ids.size() == 0) begin
                    op_beats.push_back(make_beat(oidl_pkg::ST_EMPTY, '0, 1'b1));
                end else begin
                    foreach (model_ids[i]) begin
                        op_beats.push_back(make_beat(oidl_pkg::ST_OK, model_ids[i],
                                                     i == model_ids.size() - 1));
                    end
                end
            end
            default: op_beats.push_back(make_beat(oidl_pkg::ST_OK, id, 1'b1));
        endcase
    endfunction

    task automatic send_op(input logic [oidl_pkg::MODE_W-1:0] mode,
                           input logic [oidl_pkg::ID_W-1:0] id,
                           input logic typed, input t_beat typed_beat, input bit no_gap);
        while (!no_gap && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_entry_id <= id;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_list_op(mode, id);
        if (typed) begin
            expected_beats.push_back(typed_beat);
        end else begin
            foreach (op_beats[i]) expected_beats.push_back(op_beats[i]);
        end
    endtask

    // Output side: check each beat, then pick the next ready value.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            beats_seen = beats_seen + 1;
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: status %0d out_id %h is_last %0d entry_count %0d",
                       o_status, o_out_id, o_is_last, o_entry_count);
                fail_count++;
            end else begin
                exp_beat = expected_beats.pop_front();
                if (o_status !== exp_beat.status) begin
                    $error("status: expected %0d, got %0d", exp_beat.status, o_status);
                    fail_count++;
                end
                if (o_out_id !== exp_beat.id) begin
                    $error("out_id: expected %h, got %h", exp_beat.id, o_out_id);
                    fail_count++;
                end
                if (o_is_last !== exp_beat.last) begin
                    $error("is_last: expected %0d, got %0d", exp_beat.last, o_is_last);
                    fail_count++;
                end
                if (o_entry_count !== exp_beat.count) begin
                    $error("entry_count: expected %0d, got %0d", exp_beat.count,
                           o_entry_count);
                    fail_count++;
                end
            end
        end
        if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (beats_seen >= 120 && beats_seen < 220) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        logic [oidl_pkg::ID_W-1:0]   id_pool [8];
        logic [oidl_pkg::MODE_W-1:0] mode;
        logic [oidl_pkg::ID_W-1:0]   id;
        int unsigned                 roll;
        bit                          fill_phase;

        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++) id_pool[i] = oidl_pkg::ID_W'($urandom);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_op(directed_rows[r].mode, directed_rows[r].id, directed_rows[r].typed,
                    directed_rows[r].res, 1'b0);
        end

        // Alternate fill-heavy and drain-heavy phases so full and empty both recur.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            fill_phase = ((n / PHASE_LEN) % 2) == 0;
            roll = $urandom_range(99);
            if (roll < 5) begin
                mode = oidl_pkg::MODE_NOP;
            end else if (roll < 18) begin
                mode = oidl_pkg::MODE_LIST;
            end else if (fill_phase ? (roll < 85) : (roll < 35)) begin
                mode = oidl_pkg::MODE_APPEND;
            end else begin
                mode = oidl_pkg::MODE_REMOVE;
            end
            if (mode == oidl_pkg::MODE_REMOVE && model_ids.size() != 0 &&
                $urandom_range(99) < 70) begin
                id = model_ids[$urandom_range(model_ids.size() - 1)];
            end else if ($urandom_range(1) == 1) begin
                id = id_pool[$urandom_range(7)];
            end else begin
                id = oidl_pkg::ID_W'($urandom);
            end
            send_op(mode, id, 1'b0, FROM_MODEL, n >= 80 && n < 120);
        end
        i_in_valid <= 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
